[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request kinds, result
// status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package deq_pkg;

  // field widths fixed by the interface
  localparam int KIND_W = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // one result record
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] item;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } res_t;

endpackage

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values kept in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_kind, in_value) carries requests:
//   push front, pop front, push back, pop back, list. Unused kind codes are
//   taken and dropped without a result.
//   Result channel (out_valid/out_ready) carries status, item, count, last.
//   Push and pop: one transfer in, one result out, the result shows up in the
//   cycle after the request is taken; a new request can be taken each cycle
//   while the two-entry result queue has room.
//   List: the ring RAM is read one entry per cycle, front to back, while the
//   result queue has room; each read lands in the result queue in the cycle
//   after it, so a list of N elements streams N results at one per cycle
//   while the receiver keeps up (an empty queue lists as one empty status).
//   No request is taken until the last read of a list has landed.
//   Reset empties the queue and the result queue; RAM contents are not
//   cleared, since only entries written by a push are ever read.
//   A stalled receiver fills the two-entry result queue; requests and list
//   reads then wait, no result is lost or repeated.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_item,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_last
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0]    LAST_POS = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state_r, state_nxt;
  logic [PW-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [PW-1:0]    rpos_r, rpos_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;

  logic             in_fire, out_pop;
  logic             is_push, is_pop, is_list, is_front;
  logic             full, empty;
  logic [PW-1:0]    front_dec, front_inc, rpos_inc, back_pos;
  logic [CNT_W:0]   back_sum;
  logic             wr_en, rd_en, issue_ok, list_end;
  logic [PW-1:0]    wr_addr;
  logic [VAL_W-1:0] rd_data;

  res_t             q_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic [1:0]       tot;
  logic             q_push, imm_push;
  res_t             imm_res, q_in;

  assign in_fire = in_valid & in_ready;
  assign out_pop = out_valid & out_ready;

  // request decode
  assign is_push  = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_BACK);
  assign is_pop   = (in_kind == KIND_POP_FRONT) || (in_kind == KIND_POP_BACK);
  assign is_list  = (in_kind == KIND_LIST);
  assign is_front = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_POP_FRONT);
  assign full     = (occ_r == FULL_CNT);
  assign empty    = (occ_r == '0);

  // ring pointer arithmetic
  assign front_dec = (front_r == '0) ? LAST_POS : front_r - PW'(1);
  assign front_inc = (front_r == LAST_POS) ? '0 : front_r + PW'(1);
  assign rpos_inc  = (rpos_r == LAST_POS) ? '0 : rpos_r + PW'(1);
  assign back_sum  = (CNT_W + 1)'(front_r) + (CNT_W + 1)'(occ_r);
  assign back_pos  = (back_sum >= DEPTH_W) ? PW'(back_sum - DEPTH_W) : PW'(back_sum);

  // ring store write on a push that fits
  assign wr_en   = in_fire && is_push && !full;
  assign wr_addr = is_front ? front_dec : back_pos;

  deq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rpos_r),
    .rd_data (rd_data)
  );

  // room in the result queue for a list read issued now
  assign tot      = cnt_r + {1'b0, pend_r};
  assign issue_ok = (tot < 2'd2) || out_pop;
  assign list_end = (idx_r == occ_r - CNT_W'(1));

  // request and list sequencing
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    rpos_nxt      = rpos_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    rd_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_push && !full) begin
            occ_nxt = occ_r + CNT_W'(1);
            if (is_front) begin
              front_nxt = front_dec;
            end
          end else if (is_pop && !empty) begin
            occ_nxt = occ_r - CNT_W'(1);
            if (is_front) begin
              front_nxt = front_inc;
            end
          end else if (is_list && !empty) begin
            state_nxt = S_LIST;
            idx_nxt   = '0;
            rpos_nxt  = front_r;
          end
        end
      end
      S_LIST: begin
        if (issue_ok) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = list_end;
          idx_nxt       = idx_r + CNT_W'(1);
          rpos_nxt      = rpos_inc;
          if (list_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rpos_r      <= rpos_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // single result of push, pop or empty list
  assign imm_push = in_fire && (is_push || is_pop || (is_list && empty));
  always_comb begin
    imm_res.status = STAT_OK;
    if (is_push && full) begin
      imm_res.status = STAT_FULL;
    end else if (empty && !is_push) begin
      imm_res.status = STAT_EMPTY;
    end
    imm_res.item  = '0;
    imm_res.count = occ_nxt;
    imm_res.last  = 1'b1;
  end

  // result queue input: landed list read or immediate result
  assign q_push = imm_push || pend_r;
  always_comb begin
    if (pend_r) begin
      q_in.status = STAT_OK;
      q_in.item   = rd_data;
      q_in.count  = occ_r;
      q_in.last   = pend_last_r;
    end else begin
      q_in = imm_res;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= ~wp_r;
      end
      if (out_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, q_push} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wp_r] <= q_in;
    end
  end

  assign in_ready   = (state_r == S_IDLE) && !pend_r && (cnt_r < 2'd2);
  assign out_valid  = (cnt_r != '0);
  assign out_status = q_r[rp_r].status;
  assign out_item   = q_r[rp_r].item;
  assign out_count  = q_r[rp_r].count;
  assign out_last   = q_r[rp_r].last;

`ifndef SYNTHESIS
  // occupancy never goes past the ring size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy above depth");

  // result queue never overflows
  a_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && (cnt_r == 2'd2) && !out_pop))
    else $error("result queue overflow");

  // a rejected push leaves occupancy and front alone
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_push && full) |=> ($stable(occ_r) && $stable(front_r)))
    else $error("rejected push changed state");

  // listing only runs over a non-empty queue
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (!empty && (idx_r < occ_r)))
    else $error("list walk out of range");

  // a list read always lands in the result queue next cycle
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (pend_r && q_push))
    else $error("list read lost");
`endif

endmodule

[design/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
